### rtl/depth_pixel_backprojection_assert.svh
// Assertion macros for the depth pixel back-projection block.
// Used by the top level only; no dependencies.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
// No dependencies.
package dpb_pkg;

    localparam int PIXEL_COORD_BITS = 10;
    localparam int CFG_IDX_W        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_FOCAL  = 3'd0,
        CFG_PRINCIPAL  = 3'd1,
        CFG_ROW0_ROT   = 3'd2,
        CFG_ROW0_REST  = 3'd3,
        CFG_ROW1_ROT   = 3'd4,
        CFG_ROW1_REST  = 3'd5,
        CFG_ROW2_ROT   = 3'd6,
        CFG_ROW2_REST  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [PIXEL_COORD_BITS-1:0] pixel_col;
        logic [PIXEL_COORD_BITS-1:0] pixel_row;
        logic [31:0]                 depth_value;
        logic                        depth_ok;
        logic [31:0]                 pixel_color;
    } t_pix_in;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               point_ok;
        logic [31:0]        point_color;
    } t_pt_out;

    // Load enables of the camera-axis stages
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } t_axis_ctl;

endpackage

### rtl/dpb_cam_axis.sv
// One image axis of the back-projection: offset, 1/f scale, depth scale.
// Five register stages (2..6), advanced by enables from the top level. Uses dpb_pkg.
module dpb_cam_axis #(
    parameter int P_PIXEL_COORD_BITS = dpb_pkg::PIXEL_COORD_BITS
) (
    input  logic                          i_clk,
    input  dpb_pkg::t_axis_ctl            i_ctl,
    input  logic [P_PIXEL_COORD_BITS-1:0] i_pix,
    input  logic signed [31:0]            i_centre,
    input  logic signed [31:0]            i_inv_f,
    input  logic [31:0]                   i_depth,
    output logic signed [32:0]            o_cam
);

    localparam int DX_W = (P_PIXEL_COORD_BITS + 17 > 33) ? P_PIXEL_COORD_BITS + 18 : 34;
    localparam int P1_W = DX_W + 32;

    localparam logic signed [P1_W-1:0] RND30  = P1_W'(64'sd536870912);
    localparam logic signed [P1_W-1:0] NX_MAX = P1_W'(64'sd2147483647);
    localparam logic signed [P1_W-1:0] NX_MIN = P1_W'(-64'sd2147483648);
    localparam logic signed [64:0]     RND16  = 65'sd32768;
    localparam logic signed [48:0]     CAM_MAX = 49'sd4294967295;
    localparam logic signed [48:0]     CAM_MIN = -49'sd4294967295;

    logic signed [DX_W-1:0] r_dx, n_dx;
    logic signed [P1_W-1:0] r_p1, n_p1;
    logic signed [31:0]     r_nx, n_nx;
    logic signed [64:0]     r_p2, n_p2;
    logic signed [32:0]     r_cam, n_cam;

    logic signed [P1_W-1:0] v1;
    logic signed [48:0]     v2;

    always_comb begin
        n_dx = DX_W'($signed({1'b0, i_pix, 16'h0000})) - DX_W'(i_centre);
        n_p1 = P1_W'(r_dx) * P1_W'(i_inv_f);

        v1 = (r_p1 + RND30) >>> 30;
        if (v1 > NX_MAX) begin
            n_nx = 32'sh7fffffff;
        end else if (v1 < NX_MIN) begin
            n_nx = 32'sh80000000;
        end else begin
            n_nx = 32'(v1);
        end

        n_p2 = 65'(r_nx) * 65'($signed({1'b0, i_depth}));

        v2 = 49'((r_p2 + RND16) >>> 16);
        if (v2 > CAM_MAX) begin
            n_cam = 33'(CAM_MAX);
        end else if (v2 < CAM_MIN) begin
            n_cam = 33'(CAM_MIN);
        end else begin
            n_cam = 33'(v2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_dx <= n_dx;
        end
        if (i_ctl.en3) begin
            r_p1 <= n_p1;
        end
        if (i_ctl.en4) begin
            r_nx <= n_nx;
        end
        if (i_ctl.en5) begin
            r_p2 <= n_p2;
        end
        if (i_ctl.en6) begin
            r_cam <= n_cam;
        end
    end

    assign o_cam = r_cam;

endmodule

### rtl/depth_pixel_backprojection.sv
// Depth pixel back-projection: nine register stages from input transfer to o_valid.
// Throughput one pixel per cycle unless i_stall holds the pipeline; each stage has a valid bit,
// the longest paths being one 34x32 or 33x32 multiply per stage.
// A stalled stage holds; empty stages ahead of it still fill.
// Reset (sync, active low) clears valid bits and all configuration registers.
// Uses dpb_pkg, dpb_cam_axis and depth_pixel_backprojection_assert.svh.
`include "depth_pixel_backprojection_assert.svh"

module depth_pixel_backprojection #(
    parameter int P_PIXEL_COORD_BITS = dpb_pkg::PIXEL_COORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  dpb_pkg::t_pix_in                i_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output dpb_pkg::t_pt_out                o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);

    localparam int NSTG = 9;

    logic [63:0] r_inv_focal;
    logic [63:0] r_principal;
    logic [63:0] r_row_rot  [3];
    logic [63:0] r_row_rest [3];

    logic [NSTG:1]      r_vld;
    logic [NSTG+1:1]    rdy;
    dpb_pkg::t_pix_in   r_pix [1:8];
    dpb_pkg::t_axis_ctl ctl;

    logic signed [32:0] cam_x, cam_y, cam_z;
    logic signed [64:0] r_prod [3][3];
    logic signed [36:0] r_acc  [3];
    logic signed [31:0] world  [3];
    dpb_pkg::t_pt_out   r_out;

    // Config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_focal <= '0;
            r_principal <= '0;
            for (int i = 0; i < 3; i++) begin
                r_row_rot[i]  <= '0;
                r_row_rest[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dpb_pkg::t_cfg_idx'(i_cfg_index))
                dpb_pkg::CFG_INV_FOCAL: r_inv_focal   <= i_cfg_data;
                dpb_pkg::CFG_PRINCIPAL: r_principal   <= i_cfg_data;
                dpb_pkg::CFG_ROW0_ROT:  r_row_rot[0]  <= i_cfg_data;
                dpb_pkg::CFG_ROW0_REST: r_row_rest[0] <= i_cfg_data;
                dpb_pkg::CFG_ROW1_ROT:  r_row_rot[1]  <= i_cfg_data;
                dpb_pkg::CFG_ROW1_REST: r_row_rest[1] <= i_cfg_data;
                dpb_pkg::CFG_ROW2_ROT:  r_row_rot[2]  <= i_cfg_data;
                dpb_pkg::CFG_ROW2_REST: r_row_rest[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-stage ready: a stage loads when empty or when its content moves on
    always_comb begin
        rdy[NSTG+1] = !i_stall;
        for (int k = NSTG; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[1];
    assign ctl.en2 = rdy[2];
    assign ctl.en3 = rdy[3];
    assign ctl.en4 = rdy[4];
    assign ctl.en5 = rdy[5];
    assign ctl.en6 = rdy[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Sideband: pixel fields travel with the stages
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_pix[1] <= i_in;
        end
        for (int k = 2; k <= 8; k++) begin
            if (rdy[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    dpb_cam_axis #(
        .P_PIXEL_COORD_BITS (P_PIXEL_COORD_BITS)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_pix    (P_PIXEL_COORD_BITS'(r_pix[1].pixel_col)),
        .i_centre ($signed(r_principal[31:0])),
        .i_inv_f  ($signed(r_inv_focal[31:0])),
        .i_depth  (r_pix[4].depth_value),
        .o_cam    (cam_x)
    );

    dpb_cam_axis #(
        .P_PIXEL_COORD_BITS (P_PIXEL_COORD_BITS)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_pix    (P_PIXEL_COORD_BITS'(r_pix[1].pixel_row)),
        .i_centre ($signed(r_principal[63:32])),
        .i_inv_f  ($signed(r_inv_focal[63:32])),
        .i_depth  (r_pix[4].depth_value),
        .o_cam    (cam_y)
    );

    assign cam_z = $signed({1'b0, r_pix[6].depth_value});

    // Stage 7: rotation products
    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i][0] <= 65'($signed(r_row_rot[i][31:0]))  * 65'(cam_x);
                r_prod[i][1] <= 65'($signed(r_row_rot[i][63:32])) * 65'(cam_y);
                r_prod[i][2] <= 65'($signed(r_row_rest[i][31:0])) * 65'(cam_z);
            end
        end
    end

    // Stage 8: sum and round to Q16.16
    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= 37'((67'(r_prod[i][0]) + 67'(r_prod[i][1])
                                 + 67'(r_prod[i][2]) + 67'sd536870912) >>> 30);
            end
        end
    end

    // Stage 9: translation, saturation, invalid masking
    always_comb begin
        logic signed [37:0] w;
        for (int i = 0; i < 3; i++) begin
            w = 38'($signed(r_row_rest[i][63:32])) + 38'(r_acc[i]);
            if (w > 38'sd2147483647) begin
                world[i] = 32'sh7fffffff;
            end else if (w < -38'sd2147483648) begin
                world[i] = 32'sh80000000;
            end else begin
                world[i] = 32'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[9]) begin
            if (r_pix[8].depth_ok) begin
                r_out.world_x     <= world[0];
                r_out.world_y     <= world[1];
                r_out.world_z     <= world[2];
                r_out.point_ok    <= 1'b1;
                r_out.point_color <= r_pix[8].pixel_color;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_valid = r_vld[NSTG];
    assign o_out   = r_out;

    `DPB_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, o_valid && !o_out.point_ok, o_out.world_x == 0 && o_out.world_y == 0 && o_out.world_z == 0 && o_out.point_color == 0, "invalid point with nonzero payload")
    `DPB_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, (&r_vld) && i_stall, "input stalled with room in the pipeline")
    `DPB_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, o_valid && !i_stall && !r_vld[NSTG-1], !o_valid, "output transfer repeated")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for depth_pixel_backprojection: random and directed
// pixels against a fixed-point back-projection predictor, random sender idling and receiver stalls.
// Depends on dpb_pkg and the depth_pixel_backprojection RTL.
module testbench;

    typedef logic signed [127:0] t_wide;
    typedef logic [63:0] t_regset [8];

    localparam int    PIX_W     = dpb_pkg::PIXEL_COORD_BITS;
    localparam t_wide HALF_Q30  = 128'sd1 <<< 29;
    localparam t_wide HALF_Q16  = 128'sd1 <<< 15;
    localparam t_wide S32_MAX_W = 128'sd2147483647;
    localparam t_wide S32_MIN_W = -128'sd2147483648;
    localparam t_wide CAM_LIM_W = 128'sd4294967295;
    localparam int    LIMIT_CYCLES = 200000;
    localparam int    HOLD_CYCLES  = 400;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    dpb_pkg::t_pix_in  in_item = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    dpb_pkg::t_pt_out  out_pt;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    dpb_pkg::t_cfg_idx cfg_index = dpb_pkg::CFG_INV_FOCAL;
    logic [63:0] cfg_data = '0;

    dpb_pkg::t_pix_in pending_pixels [$];
    dpb_pkg::t_pt_out expected_pts [$];
    logic [63:0] cfg_shadow [8] = '{default: '0};

    int  send_idle_pct = 28;
    int  recv_idle_pct = 77;
    logic tx_pause = 1'b0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int  rx_hold_left = 0;
    int  err_count = 0;
    int  cycle_count = 0;

    depth_pixel_backprojection DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_in        (in_item),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_out       (out_pt),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic t_wide clamp_wide(t_wide v, t_wide lo, t_wide hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Camera coordinate along one image axis, Q16.16.
    function automatic t_wide camera_axis(logic [PIX_W-1:0] pix,
                                          logic [31:0] centre, logic [31:0] inv_f,
                                          logic [31:0] depth);
        t_wide p, c, f, d, n;
        p = t_wide'(pix);
        c = t_wide'($signed(centre));
        f = t_wide'($signed(inv_f));
        d = t_wide'(depth);
        n = clamp_wide(((((p <<< 16) - c) * f) + HALF_Q30) >>> 30, S32_MIN_W, S32_MAX_W);
        return clamp_wide(((n * d) + HALF_Q16) >>> 16, -CAM_LIM_W, CAM_LIM_W);
    endfunction

    function automatic logic [31:0] world_axis(logic [63:0] rot, logic [63:0] rest,
                                               t_wide cx, t_wide cy, t_wide cz);
        t_wide r0, r1, r2, t, w;
        r0 = t_wide'($signed(rot[31:0]));
        r1 = t_wide'($signed(rot[63:32]));
        r2 = t_wide'($signed(rest[31:0]));
        t  = t_wide'($signed(rest[63:32]));
        w  = t + (((r0 * cx + r1 * cy + r2 * cz) + HALF_Q30) >>> 30);
        w  = clamp_wide(w, S32_MIN_W, S32_MAX_W);
        return w[31:0];
    endfunction

    function automatic dpb_pkg::t_pt_out predict_point(dpb_pkg::t_pix_in px);
        dpb_pkg::t_pt_out pt;
        t_wide cx, cy, cz;
        pt = '0;
        if (!px.depth_ok)
            return pt;
        cx = camera_axis(px.pixel_col, cfg_shadow[dpb_pkg::CFG_PRINCIPAL][31:0],
                         cfg_shadow[dpb_pkg::CFG_INV_FOCAL][31:0], px.depth_value);
        cy = camera_axis(px.pixel_row, cfg_shadow[dpb_pkg::CFG_PRINCIPAL][63:32],
                         cfg_shadow[dpb_pkg::CFG_INV_FOCAL][63:32], px.depth_value);
        cz = t_wide'(px.depth_value);
        pt.world_x = world_axis(cfg_shadow[dpb_pkg::CFG_ROW0_ROT],
                                cfg_shadow[dpb_pkg::CFG_ROW0_REST], cx, cy, cz);
        pt.world_y = world_axis(cfg_shadow[dpb_pkg::CFG_ROW1_ROT],
                                cfg_shadow[dpb_pkg::CFG_ROW1_REST], cx, cy, cz);
        pt.world_z = world_axis(cfg_shadow[dpb_pkg::CFG_ROW2_ROT],
                                cfg_shadow[dpb_pkg::CFG_ROW2_REST], cx, cy, cz);
        pt.point_ok    = 1'b1;
        pt.point_color = px.pixel_color;
        return pt;
    endfunction

    function automatic dpb_pkg::t_pix_in rand_pixel();
        dpb_pkg::t_pix_in px;
        px.pixel_col = PIX_W'($urandom_range(1023));
        px.pixel_row = PIX_W'($urandom_range(1023));
        case ($urandom_range(9))
            0:       px.depth_value = '0;
            1, 2:    px.depth_value = $urandom;
            default: px.depth_value = $urandom_range(10 << 16);
        endcase
        px.depth_ok    = ($urandom_range(9) != 0);
        px.pixel_color = $urandom;
        return px;
    endfunction

    function automatic void queue_pixel(int col, int row, logic [31:0] depth,
                                        logic ok, logic [31:0] color);
        dpb_pkg::t_pix_in px;
        px.pixel_col   = PIX_W'(col);
        px.pixel_row   = PIX_W'(row);
        px.depth_value = depth;
        px.depth_ok    = ok;
        px.pixel_color = color;
        pending_pixels.push_back(px);
    endfunction

    // Rotation entry in [-1.0, 1.0], Q2.30
    function automatic logic [31:0] rand_q30();
        return 32'($urandom_range(32'h8000_0000)) - ONE_Q30;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_pixels.size() != 0 || expected_pts.size() != 0);
    endtask

    task automatic program_regs(input t_regset vals);
        dpb_pkg::t_cfg_idx idx;
        idx = idx.first();
        cfg_valid <= 1'b1;
        repeat (idx.num()) begin
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            do @(posedge clk);
            while (!cfg_ready);
            cfg_shadow[idx] = vals[idx];
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    // Driver: head of the queue stays on the bus until its transfer.
    always @(posedge clk) begin : driver
        if (in_valid && !in_stall)
            expected_pts.push_back(predict_point(pending_pixels.pop_front()));
        if (!in_valid || !in_stall) begin
            if (pending_pixels.size() != 0 && !tx_pause &&
                $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_item  <= pending_pixels[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : hold_counter
        if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            rx_hold_left <= HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge clk) begin : monitor
        dpb_pkg::t_pt_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_pts.size() == 0) begin
                flag_error("result transfer with nothing expected");
            end else begin
                want = expected_pts.pop_front();
                check_field("world_x", out_pt.world_x, want.world_x);
                check_field("world_y", out_pt.world_y, want.world_y);
                check_field("world_z", out_pt.world_z, want.world_z);
                check_field("point_ok", 32'(out_pt.point_ok), 32'(want.point_ok));
                check_field("point_color", out_pt.point_color, want.point_color);
            end
        end
        out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : sequencer
        t_regset regs;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: all zero
        queue_pixel(0, 0, 32'h0, 1'b1, 32'h0);
        queue_pixel(1023, 1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_pixel(5, 7, 32'h0001_0000, 1'b0, 32'hA5A5_A5A5);
        pending_pixels.push_back(rand_pixel());
        wait_drained();

        // typical intrinsics, identity rotation, small offset
        regs[dpb_pkg::CFG_INV_FOCAL] = {32'd2064888, 32'd2045222};
        regs[dpb_pkg::CFG_PRINCIPAL] = {32'd15695872, 32'd20938752};
        regs[dpb_pkg::CFG_ROW0_ROT]  = {32'h0, ONE_Q30};
        regs[dpb_pkg::CFG_ROW0_REST] = {32'h0001_0000, 32'h0};
        regs[dpb_pkg::CFG_ROW1_ROT]  = {ONE_Q30, 32'h0};
        regs[dpb_pkg::CFG_ROW1_REST] = {32'hFFFE_0000, 32'h0};
        regs[dpb_pkg::CFG_ROW2_ROT]  = {32'h0, 32'h0};
        regs[dpb_pkg::CFG_ROW2_REST] = {32'h0000_8000, ONE_Q30};
        program_regs(regs);
        queue_pixel(0, 0, 32'h0001_0000, 1'b1, 32'h0000_0000);
        queue_pixel(1023, 1023, 32'h0001_0000, 1'b1, 32'hFFFF_FFFF);
        queue_pixel(0, 1023, 32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
        queue_pixel(1023, 0, 32'hFFFF_FFFF, 1'b1, 32'h8765_4321);
        queue_pixel(320, 240, 32'h0, 1'b1, 32'h00FF_00FF);
        queue_pixel(320, 240, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        queue_pixel(100, 900, 32'h0001_0000, 1'b0, 32'h0BAD_F00D);
        queue_pixel(319, 239, 32'h0003_8000, 1'b1, 32'hFF00_FF00);
        repeat (4) pending_pixels.push_back(rand_pixel());
        wait_drained();

        // positive extremes: intermediates and results saturate high
        regs = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
        regs[dpb_pkg::CFG_PRINCIPAL] = 64'h8000_0000_8000_0000;
        program_regs(regs);
        queue_pixel(1023, 1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        repeat (150) pending_pixels.push_back(rand_pixel());
        wait_drained();

        // negative extremes
        regs = '{default: 64'h8000_0000_8000_0000};
        regs[dpb_pkg::CFG_PRINCIPAL] = 64'h7FFF_FFFF_7FFF_FFFF;
        program_regs(regs);
        repeat (150) pending_pixels.push_back(rand_pixel());
        wait_drained();

        // swapped idling, fully random registers, one sender pause mid-stream
        send_idle_pct <= 77;
        recv_idle_pct <= 28;
        foreach (regs[k])
            regs[k] = {$urandom, $urandom};
        program_regs(regs);
        repeat (200) pending_pixels.push_back(rand_pixel());
        while (pending_pixels.size() > 100)
            @(posedge clk);
        tx_pause <= 1'b1;
        do @(posedge clk);
        while (in_valid || expected_pts.size() != 0);
        tx_pause <= 1'b0;
        wait_drained();

        // no idling: plausible random camera pose
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        regs[dpb_pkg::CFG_INV_FOCAL] = {32'($urandom_range(1 << 24)),
                                        32'($urandom_range(1 << 24))};
        regs[dpb_pkg::CFG_PRINCIPAL] = {32'($urandom_range(1023 << 16)),
                                        32'($urandom_range(1023 << 16))};
        regs[dpb_pkg::CFG_ROW0_ROT]  = {rand_q30(), rand_q30()};
        regs[dpb_pkg::CFG_ROW1_ROT]  = {rand_q30(), rand_q30()};
        regs[dpb_pkg::CFG_ROW2_ROT]  = {rand_q30(), rand_q30()};
        regs[dpb_pkg::CFG_ROW0_REST] = {32'($urandom_range(1 << 21)) - 32'(1 << 20),
                                        rand_q30()};
        regs[dpb_pkg::CFG_ROW1_REST] = {32'($urandom_range(1 << 21)) - 32'(1 << 20),
                                        rand_q30()};
        regs[dpb_pkg::CFG_ROW2_REST] = {32'($urandom_range(1 << 21)) - 32'(1 << 20),
                                        rand_q30()};
        program_regs(regs);
        repeat (250) pending_pixels.push_back(rand_pixel());
        wait_drained();

        // back to the typical pose; long receiver hold fills the pipeline
        regs[dpb_pkg::CFG_INV_FOCAL] = {32'd2064888, 32'd2045222};
        regs[dpb_pkg::CFG_PRINCIPAL] = {32'd15695872, 32'd20938752};
        regs[dpb_pkg::CFG_ROW0_ROT]  = {32'h0, ONE_Q30};
        regs[dpb_pkg::CFG_ROW0_REST] = {32'h0001_0000, 32'h0};
        regs[dpb_pkg::CFG_ROW1_ROT]  = {ONE_Q30, 32'h0};
        regs[dpb_pkg::CFG_ROW1_REST] = {32'hFFFE_0000, 32'h0};
        regs[dpb_pkg::CFG_ROW2_ROT]  = {32'h0, 32'h0};
        regs[dpb_pkg::CFG_ROW2_REST] = {32'h0000_8000, ONE_Q30};
        program_regs(regs);
        repeat (300) pending_pixels.push_back(rand_pixel());
        while (pending_pixels.size() > 250)
            @(posedge clk);
        hold_req <= ~hold_req;
        wait_drained();

        repeat (20) @(posedge clk);
        if (expected_pts.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_pts.size()));
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_cam_axis.sv
rtl/depth_pixel_backprojection.sv
sim/testbench.sv
